[rtl/byte_ring_fifo_with_peek_defines.svh]
// Assertion macros for the RTL files that check their own logic (included by brf_back).
`ifndef BYTE_RING_FIFO_WITH_PEEK_DEFINES_SVH
`define BYTE_RING_FIFO_WITH_PEEK_DEFINES_SVH
`ifndef SYNTHESIS
`define BRF_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`define BRF_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define BRF_ASSERT(label, cond, msg)
`define BRF_IMPLY(label, ante, cons, msg)
`endif
`endif

[rtl/brf_pkg.sv]
package brf_pkg;

   localparam int CMD_W      = 3;
   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = 11;
   localparam int JOB_ADDR_W = 12;
   localparam int JOBQ_DEPTH = 2;
   localparam int OUT_DEPTH  = 4;

   localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DISCARD = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [BYTE_W-1:0]  data_byte;
      logic [COUNT_W-1:0] length;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  read_byte;
      logic [COUNT_W-1:0] granted_count;
      logic               last;
      logic [COUNT_W-1:0] used_count;
      logic               empty_res;
   } rsp_type;

   typedef enum logic [1:0] {
      JOB_STATUS,
      JOB_WRITE,
      JOB_READ
   } job_kind_type;

   typedef struct packed {
      job_kind_type          kind;
      logic [JOB_ADDR_W-1:0] addr;
      logic [BYTE_W-1:0]     data_byte;
      logic [COUNT_W-1:0]    granted_count;
      logic [COUNT_W-1:0]    used_count;
      logic                  empty_res;
   } job_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

endpackage

[rtl/brf_front.sv]
module brf_front
   import brf_pkg::*;
#(
   parameter int DEPTH     = 1024,
   parameter int BURST_MAX = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   input  logic    job_full,
   output logic    job_push,
   output job_type job
);

   localparam int CNT_W = $clog2(2 * DEPTH);
   localparam int W     = (CNT_W + 1 > COUNT_W) ? CNT_W + 1 : COUNT_W;
   localparam logic [W-1:0] MOD   = W'(2 * DEPTH);
   localparam logic [W-1:0] DEP   = W'(DEPTH);
   localparam logic [W-1:0] BURST = W'(BURST_MAX);

   logic [CNT_W-1:0] wr_cnt_ff, wr_cnt_in, wr_next;
   logic [CNT_W-1:0] rd_cnt_ff, rd_cnt_in, rd_next;
   logic [W-1:0]     wr_ext, rd_ext, used, len_ext, disc_g, burst_g, after;
   logic             accept;

   function automatic logic [CNT_W-1:0] advance(input logic [CNT_W-1:0] cnt,
                                                input logic [W-1:0] step);
      logic [W-1:0] s;
      s = W'(cnt) + step;
      if (s >= MOD) begin
         s = s - MOD;
      end
      return CNT_W'(s);
   endfunction

   function automatic logic [JOB_ADDR_W-1:0] addr_of(input logic [CNT_W-1:0] cnt);
      logic [W-1:0] a;
      a = W'(cnt);
      if (a >= DEP) begin
         a = a - DEP;
      end
      return JOB_ADDR_W'(a);
   endfunction

   assign accept   = req_push & ~job_full;
   assign req_full = job_full;
   assign job_push = accept;

   always_comb begin
      wr_ext  = W'(wr_cnt_ff);
      rd_ext  = W'(rd_cnt_ff);
      used    = (wr_ext >= rd_ext) ? (wr_ext - rd_ext) : (wr_ext + MOD - rd_ext);
      len_ext = W'(req_data.length);
      disc_g  = (len_ext < used) ? len_ext : used;
      burst_g = (disc_g > BURST) ? BURST : disc_g;
   end

   always_comb begin
      job               = '0;
      job.kind          = JOB_STATUS;
      after             = used;
      wr_next           = wr_cnt_ff;
      rd_next           = rd_cnt_ff;
      case (req_data.command)
         CMD_PUSH: begin
            if (used < DEP) begin
               job.kind          = JOB_WRITE;
               job.addr          = addr_of(wr_cnt_ff);
               job.data_byte     = req_data.data_byte;
               job.granted_count = COUNT_W'(1);
               after             = used + W'(1);
               wr_next           = advance(wr_cnt_ff, W'(1));
            end
         end
         CMD_PEEK, CMD_POP: begin
            if (burst_g != '0) begin
               job.kind          = JOB_READ;
               job.addr          = addr_of(rd_cnt_ff);
               job.granted_count = COUNT_W'(burst_g);
            end
            if (req_data.command == CMD_POP) begin
               after   = used - burst_g;
               rd_next = advance(rd_cnt_ff, burst_g);
            end
         end
         CMD_DISCARD: begin
            job.granted_count = COUNT_W'(disc_g);
            after             = used - disc_g;
            rd_next           = advance(rd_cnt_ff, disc_g);
         end
         CMD_CLEAR: begin
            after   = '0;
            wr_next = '0;
            rd_next = '0;
         end
         default: begin
         end
      endcase
      job.used_count = COUNT_W'(after);
      job.empty_res  = (after == '0);
      wr_cnt_in      = accept ? wr_next : wr_cnt_ff;
      rd_cnt_in      = accept ? rd_next : rd_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_cnt_ff <= '0;
         rd_cnt_ff <= '0;
      end else begin
         wr_cnt_ff <= wr_cnt_in;
         rd_cnt_ff <= rd_cnt_in;
      end
   end

endmodule

[rtl/brf_queue.sv]
module brf_queue
   import brf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type job_in,
   output logic    full,
   input  logic    pop,
   output job_type job_out,
   output logic    empty
);

   localparam int PW = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
   localparam int CW = $clog2(JOBQ_DEPTH + 1);

   job_type         slots_ff [JOBQ_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push_fire, pop_fire;

   assign full      = (count_ff == CW'(JOBQ_DEPTH));
   assign empty     = (count_ff == '0);
   assign push_fire = push & ~full;
   assign pop_fire  = pop & ~empty;
   assign job_out   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PW'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PW'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(push_fire) - CW'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slots_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

[rtl/brf_back.sv]
`include "byte_ring_fifo_with_peek_defines.svh"

module brf_back
   import brf_pkg::*;
#(
   parameter int DEPTH     = 1024,
   parameter int BURST_MAX = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_empty,
   input  job_type job,
   output logic    job_pop,
   input  logic    rsp_pop,
   output rsp_type rsp_data,
   output logic    rsp_empty
);

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RUN_W = $clog2(BURST_MAX + 1);
   localparam int OPW   = $clog2(OUT_DEPTH);
   localparam int OCW   = $clog2(OUT_DEPTH + 1);

   back_state_type     state_ff, state_in;
   logic [AW-1:0]      run_addr_ff, run_addr_in;
   logic [RUN_W-1:0]   run_left_ff, run_left_in;
   logic [COUNT_W-1:0] run_granted_ff, run_granted_in;
   logic [COUNT_W-1:0] run_used_ff, run_used_in;
   logic               run_empty_ff, run_empty_in;

   logic               issue_ok, issue, is_read, mem_we;
   logic [AW-1:0]      mem_addr;
   rsp_type            beat;

   logic [BYTE_W-1:0]  store_ff [DEPTH];
   logic [BYTE_W-1:0]  mem_q_ff;
   logic               r1_valid_ff;
   logic               r1_read_ff;
   rsp_type            r1_ff;
   rsp_type            r1_item;

   rsp_type            out_buf_ff [OUT_DEPTH];
   logic [OPW-1:0]     out_wr_ptr_ff, out_rd_ptr_ff;
   logic [OCW-1:0]     out_count_ff, out_count_in;
   logic               out_pop_fire;

   function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
      return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
   endfunction

   assign issue_ok = ({1'b0, out_count_ff} + (OCW + 1)'(r1_valid_ff))
                     < (OCW + 1)'(OUT_DEPTH);

   always_comb begin
      issue              = 1'b0;
      job_pop            = 1'b0;
      mem_we             = 1'b0;
      is_read            = 1'b0;
      mem_addr           = run_addr_ff;
      beat               = '0;
      beat.granted_count = run_granted_ff;
      beat.used_count    = run_used_ff;
      beat.empty_res     = run_empty_ff;
      beat.last          = 1'b1;
      case (state_ff)
         BACK_RUN: begin
            if (issue_ok) begin
               issue     = 1'b1;
               is_read   = 1'b1;
               beat.last = (run_left_ff == RUN_W'(1));
            end
         end
         BACK_IDLE: begin
            if (issue_ok && !job_empty) begin
               job_pop            = 1'b1;
               issue              = 1'b1;
               mem_addr           = AW'(job.addr);
               beat.granted_count = job.granted_count;
               beat.used_count    = job.used_count;
               beat.empty_res     = job.empty_res;
               case (job.kind)
                  JOB_WRITE: begin
                     mem_we = 1'b1;
                  end
                  JOB_READ: begin
                     is_read   = 1'b1;
                     beat.last = (job.granted_count == COUNT_W'(1));
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      run_addr_in    = run_addr_ff;
      run_left_in    = run_left_ff;
      run_granted_in = run_granted_ff;
      run_used_in    = run_used_ff;
      run_empty_in   = run_empty_ff;
      case (state_ff)
         BACK_RUN: begin
            if (issue_ok) begin
               run_addr_in = next_addr(run_addr_ff);
               run_left_in = run_left_ff - 1'b1;
               if (run_left_ff == RUN_W'(1)) begin
                  state_in = BACK_IDLE;
               end
            end
         end
         BACK_IDLE: begin
            if (issue_ok && !job_empty && job.kind == JOB_READ
                && job.granted_count != COUNT_W'(1)) begin
               state_in       = BACK_RUN;
               run_addr_in    = next_addr(AW'(job.addr));
               run_left_in    = RUN_W'(job.granted_count - COUNT_W'(1));
               run_granted_in = job.granted_count;
               run_used_in    = job.used_count;
               run_empty_in   = job.empty_res;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BACK_IDLE;
         run_left_ff <= '0;
         r1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         run_left_ff <= run_left_in;
         r1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      run_addr_ff    <= run_addr_in;
      run_granted_ff <= run_granted_in;
      run_used_ff    <= run_used_in;
      run_empty_ff   <= run_empty_in;
      r1_ff          <= beat;
      r1_read_ff     <= is_read;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_addr] <= job.data_byte;
      end
      mem_q_ff <= store_ff[mem_addr];
   end

   always_comb begin
      r1_item           = r1_ff;
      r1_item.read_byte = r1_read_ff ? mem_q_ff : '0;
   end

   assign rsp_empty    = (out_count_ff == '0);
   assign rsp_data     = out_buf_ff[out_rd_ptr_ff];
   assign out_pop_fire = rsp_pop & ~rsp_empty;
   assign out_count_in = out_count_ff + OCW'(r1_valid_ff) - OCW'(out_pop_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ptr_ff <= '0;
         out_rd_ptr_ff <= '0;
         out_count_ff  <= '0;
      end else begin
         if (r1_valid_ff) begin
            out_wr_ptr_ff <= out_wr_ptr_ff + 1'b1;
         end
         if (out_pop_fire) begin
            out_rd_ptr_ff <= out_rd_ptr_ff + 1'b1;
         end
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (r1_valid_ff) begin
         out_buf_ff[out_wr_ptr_ff] <= r1_item;
      end
   end

   `BRF_ASSERT(a_out_count_bound, out_count_ff <= OCW'(OUT_DEPTH), "Output buffer overflow.")
   `BRF_IMPLY(a_r1_has_room, r1_valid_ff, out_count_ff < OCW'(OUT_DEPTH), "No room for beat.")
   `BRF_IMPLY(a_run_left_set, state_ff == BACK_RUN, run_left_ff != '0, "Empty read run.")

endmodule

[rtl/byte_ring_fifo_with_peek.sv]
// Byte FIFO on a ring of DEPTH entries with push, peek, pop, discard and clear commands.
// A command is taken whenever the internal job queue has room; the front end updates
// the write and read counters at once and hands a job to the back end, which owns the
// single-port byte memory. Push, discard, clear and undefined codes each produce one
// result, issued by the back end without entering a read run. Peek and pop return
// min(length, fill level, BURST_MAX) bytes, one per cycle through the memory read
// port while the output buffer has room, and a single status result when nothing is
// returned. A result passes through the job queue, the back end's issue register and
// the output buffer. The storage needs no clearing pass after reset.
module byte_ring_fifo_with_peek
   import brf_pkg::*;
#(
   parameter int DEPTH     = 1024,
   parameter int BURST_MAX = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   input  logic    rsp_pop,
   output rsp_type rsp_data,
   output logic    rsp_empty
);

   logic    job_push, job_full, job_pop, job_empty;
   job_type job_in, job_out;

   brf_front #(
      .DEPTH     (DEPTH),
      .BURST_MAX (BURST_MAX)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .job_full (job_full),
      .job_push (job_push),
      .job      (job_in)
   );

   brf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .job_in  (job_in),
      .full    (job_full),
      .pop     (job_pop),
      .job_out (job_out),
      .empty   (job_empty)
   );

   brf_back #(
      .DEPTH     (DEPTH),
      .BURST_MAX (BURST_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (job_out),
      .job_pop   (job_pop),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty)
   );

endmodule
